// ===== src/rtmc_pkg.sv =====
package rtmc_pkg;

   localparam int MaxGrid    = 32;
   localparam int MaxPattern = 32;
   localparam int IdxW       = $clog2(MaxGrid);
   localparam int PatIdxW    = $clog2(MaxPattern);
   localparam int CellW      = 8;
   localparam int SizeW      = 6;
   localparam int CountW     = 11;
   localparam int NumRot     = 4;
   localparam int ReqW       = ((2 * IdxW + CellW + 7) / 8) * 8;
   localparam int RspW       = ((NumRot * CountW + 7) / 8) * 8;

   localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

   typedef enum logic [1:0] {
      ACT_GRID    = 2'd0,
      ACT_PATTERN = 2'd1,
      ACT_COMPUTE = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic {
      CSR_GRID_SIZE    = 1'b0,
      CSR_PATTERN_SIZE = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ROT_0   = 2'd0,
      ROT_90  = 2'd1,
      ROT_180 = 2'd2,
      ROT_270 = 2'd3
   } rot_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             load_grid;
      logic             load_pattern;
      logic             start;
      logic [IdxW-1:0]  row;
      logic [IdxW-1:0]  col;
      logic [CellW-1:0] cell_val;
      logic [SizeW-1:0] grid_size;
      logic [SizeW-1:0] pattern_size;
   } cmd_type;

   typedef struct packed {
      logic idle;
      logic done;
   } stat_type;

endpackage

// ===== src/rtmc_core.sv =====
module rtmc_core
   import rtmc_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  cmd_type                        cmd,
   input  logic                           out_free,
   output stat_type                       stat,
   output logic [NumRot-1:0][CountW-1:0]  counts
);

   state_type state_ff, state_in;
   rot_type   t_ff, t_in;
   logic [IdxW-1:0]    r_ff, r_in, c_ff, c_in, lim_ff, lim_in;
   logic [PatIdxW-1:0] i_ff, i_in, j_ff, j_in, pm1_ff, pm1_in;
   logic [NumRot-1:0][CountW-1:0] cnt_ff, cnt_in;

   logic [CellW-1:0] grid_mem [MaxGrid*MaxGrid];
   logic [CellW-1:0] pat_mem  [MaxPattern*MaxPattern];
   logic [CellW-1:0] grid_rd_ff, pat_rd_ff;

   logic [2*IdxW-1:0]    grid_addr;
   logic [2*PatIdxW-1:0] pat_addr;
   logic [PatIdxW-1:0]   pat_row, pat_col;
   logic                 sizes_ok, match, cell_last, scan_last;

   assign sizes_ok = (cmd.grid_size != '0) && (cmd.pattern_size != '0)
                     && (cmd.pattern_size <= cmd.grid_size);

   // grid cell under pattern cell (i, j) of placement (r, c)
   assign grid_addr = {r_ff + IdxW'(i_ff), c_ff + IdxW'(j_ff)};

   // turned pattern cells by index transform
   always_comb begin
      unique case (t_ff)
         ROT_0: begin
            pat_row = i_ff;
            pat_col = j_ff;
         end
         ROT_90: begin
            pat_row = pm1_ff - j_ff;
            pat_col = i_ff;
         end
         ROT_180: begin
            pat_row = pm1_ff - i_ff;
            pat_col = pm1_ff - j_ff;
         end
         ROT_270: begin
            pat_row = j_ff;
            pat_col = pm1_ff - i_ff;
         end
      endcase
   end
   assign pat_addr = {pat_row, pat_col};

   always_ff @(posedge clock) begin
      if (cmd.load_grid) begin
         grid_mem[{cmd.row, cmd.col}] <= cmd.cell_val;
      end
      if (cmd.load_pattern) begin
         pat_mem[{PatIdxW'(cmd.row), PatIdxW'(cmd.col)}] <= cmd.cell_val;
      end
      grid_rd_ff <= grid_mem[grid_addr];
      pat_rd_ff  <= pat_mem[pat_addr];
   end

   assign match     = (grid_rd_ff == pat_rd_ff);
   assign cell_last = (i_ff == pm1_ff) && (j_ff == pm1_ff);
   assign scan_last = (t_ff == ROT_270) && (c_ff == lim_ff) && (r_ff == lim_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               state_in = sizes_ok ? ST_READ : ST_DONE;
            end
         end
         ST_READ: state_in = ST_CMP;
         ST_CMP: begin
            if ((!match || cell_last) && scan_last) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      t_in   = t_ff;
      r_in   = r_ff;
      c_in   = c_ff;
      i_in   = i_ff;
      j_in   = j_ff;
      lim_in = lim_ff;
      pm1_in = pm1_ff;
      cnt_in = cnt_ff;
      if (state_ff == ST_IDLE && cmd.start) begin
         t_in   = ROT_0;
         r_in   = '0;
         c_in   = '0;
         i_in   = '0;
         j_in   = '0;
         lim_in = IdxW'(cmd.grid_size - cmd.pattern_size);
         pm1_in = PatIdxW'(cmd.pattern_size - 1'b1);
         cnt_in = '0;
      end else if (state_ff == ST_CMP) begin
         if (match && !cell_last) begin
            // advance to the next cell of this placement
            if (j_ff == pm1_ff) begin
               j_in = '0;
               i_in = i_ff + 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end else begin
            for (int k = 0; k < NumRot; k++) begin
               if (match && rot_type'(k) == t_ff && cnt_ff[k] != CountMax) begin
                  cnt_in[k] = cnt_ff[k] + 1'b1;
               end
            end
            i_in = '0;
            j_in = '0;
            // next turn, then next column, then next row
            if (t_ff != ROT_270) begin
               t_in = rot_type'(t_ff + 1'b1);
            end else begin
               t_in = ROT_0;
               if (c_ff != lim_ff) begin
                  c_in = c_ff + 1'b1;
               end else begin
                  c_in = '0;
                  r_in = r_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff   <= t_in;
      r_ff   <= r_in;
      c_ff   <= c_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      lim_ff <= lim_in;
      pm1_ff <= pm1_in;
      cnt_ff <= cnt_in;
   end

   assign stat.idle = (state_ff == ST_IDLE);
   assign stat.done = (state_ff == ST_DONE);
   assign counts    = cnt_ff;

endmodule

// ===== src/rotated_template_match_counter.sv =====
// Load items (grid or pattern cell) are accepted one per cycle while the core is idle.
// A compute item uses one compare unit that walks all placements, four turns and
// cells with early exit on a mismatch; invalid sizes finish without a compare.
// The result sits in an output register; req_tready is low while computing.
// Reset clears control state and sets both sizes to 1; stores are not cleared.
module rotated_template_match_counter
   import rtmc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqW-1:0]     req_tdata,   // row[4:0], col[9:5], cell_req[17:10], zero pad
   input  logic [1:0]          req_tuser,   // action[1:0]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspW-1:0]     rsp_tdata,   // count_rot0, count_rot90, count_rot180,
                                            // count_rot270 (11 bits each), zero pad
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [SizeW-1:0]    csr_data
);

   logic [SizeW-1:0] grid_size_ff, grid_size_in, pattern_size_ff, pattern_size_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RspW-1:0]  rsp_data_ff, rsp_data_in;
   logic             req_accept, out_free;
   cmd_type          cmd;
   stat_type         core_stat;
   logic [NumRot-1:0][CountW-1:0] counts;

   assign csr_ready = 1'b1;

   always_comb begin
      grid_size_in    = grid_size_ff;
      pattern_size_in = pattern_size_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRID_SIZE:    grid_size_in    = csr_data;
            CSR_PATTERN_SIZE: pattern_size_in = csr_data;
         endcase
      end
   end

   assign req_tready = core_stat.idle;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      cmd.load_grid    = req_accept && (req_tuser == ACT_GRID);
      cmd.load_pattern = req_accept && (req_tuser == ACT_PATTERN);
      cmd.start        = req_accept && (req_tuser == ACT_COMPUTE);
      cmd.row          = req_tdata[IdxW-1:0];
      cmd.col          = req_tdata[2*IdxW-1:IdxW];
      cmd.cell_val     = req_tdata[2*IdxW+CellW-1:2*IdxW];
      // saturate oversize registers
      cmd.grid_size    = (grid_size_ff > SizeW'(MaxGrid)) ? SizeW'(MaxGrid) : grid_size_ff;
      cmd.pattern_size = (pattern_size_ff > SizeW'(MaxPattern)) ?
                         SizeW'(MaxPattern) : pattern_size_ff;
   end

   rtmc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .out_free (out_free),
      .stat     (core_stat),
      .counts   (counts)
   );

   // output register: load when free, hold while stalled
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (core_stat.done && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RspW'(counts);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff    <= SizeW'(1);
         pattern_size_ff <= SizeW'(1);
         rsp_valid_ff    <= 1'b0;
      end else begin
         grid_size_ff    <= grid_size_in;
         pattern_size_ff <= pattern_size_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      core_stat.done |-> !req_tready)
      else $error("input ready while a result is pending in the core");

   a_compute_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> !req_tready)
      else $error("input ready right after a compute item");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[CountW-1:0] <= CountW'(MaxGrid * MaxGrid)))
      else $error("count exceeds number of placements");
`endif

endmodule

// ===== verif/rotated_template_match_counter_tb.sv =====
module rotated_template_match_counter_tb;
   import rtmc_pkg::*;

   localparam int StallLimit = 100000;
   localparam int RandomItems = 540;

   typedef struct packed {
      logic [CountW-1:0] count_rot0;
      logic [CountW-1:0] count_rot90;
      logic [CountW-1:0] count_rot180;
      logic [CountW-1:0] count_rot270;
   } count_set_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [ReqW-1:0]   req_tdata;   // row[4:0], col[9:5], cell_req[17:10], zero pad
   logic [1:0]        req_tuser;   // action[1:0]
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RspW-1:0]   rsp_tdata;   // count_rot0, count_rot90, count_rot180,
                                   // count_rot270 (11 bits each), zero pad
   logic              csr_valid;
   logic              csr_ready;
   logic              csr_index;
   logic [SizeW-1:0]  csr_data;

   // Shadow of the block's state
   logic [CellW-1:0]  grid_cells    [MaxGrid][MaxGrid];
   logic [CellW-1:0]  pattern_cells [MaxPattern][MaxPattern];
   bit                grid_loaded   [MaxGrid][MaxGrid];
   bit                pattern_loaded[MaxPattern][MaxPattern];
   logic [SizeW-1:0]  grid_side;
   logic [SizeW-1:0]  pattern_side;

   count_set_type     expected_counts[$];
   int                fail_count;
   int                quiet_cycles;
   int                rsp_hold_req;
   bit                req_gaps_on;
   bit                rsp_gaps_on;
   logic [CellW-1:0]  cell_syms[2];

   rotated_template_match_counter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(0, 2);
      else if (roll < 95) return $urandom_range(3, 8);
      else return $urandom_range(20, 60);
   endfunction

   // Mostly two symbols so that small patterns match often
   function automatic logic [CellW-1:0] pick_cell();
      if ($urandom_range(0, 15) == 0) return CellW'($urandom_range(0, 255));
      return cell_syms[$urandom_range(0, 1)];
   endfunction

   function automatic int side_used(logic [SizeW-1:0] side, int limit);
      return (int'(side) > limit) ? limit : int'(side);
   endfunction

   // Source cell in the stored pattern for cell (i, j) of the turned pattern
   function automatic void turned_src(rot_type turn, int i, int j, int p,
                                      output int sr, output int sc);
      case (turn)
         ROT_90: begin
            sr = p - 1 - j;
            sc = i;
         end
         ROT_180: begin
            sr = p - 1 - i;
            sc = p - 1 - j;
         end
         ROT_270: begin
            sr = j;
            sc = p - 1 - i;
         end
         default: begin
            sr = i;
            sc = j;
         end
      endcase
   endfunction

   function automatic count_set_type predict_match_counts();
      count_set_type tally;
      int hits[NumRot];
      int g, p, r0, c0, i, j, k, sr, sc;
      bit hit;
      tally = '0;
      hits = '{default: 0};
      g = side_used(grid_side, MaxGrid);
      p = side_used(pattern_side, MaxPattern);
      if (g == 0 || p == 0 || p > g) return tally;
      for (r0 = 0; r0 + p <= g; r0++) begin
         for (c0 = 0; c0 + p <= g; c0++) begin
            for (k = 0; k < NumRot; k++) begin
               hit = 1'b1;
               for (i = 0; i < p && hit; i++) begin
                  for (j = 0; j < p && hit; j++) begin
                     turned_src(rot_type'(k), i, j, p, sr, sc);
                     if (grid_cells[r0+i][c0+j] != pattern_cells[sr][sc]) hit = 1'b0;
                  end
               end
               if (hit && hits[k] < int'(CountMax)) hits[k]++;
            end
         end
      end
      tally.count_rot0   = CountW'(hits[ROT_0]);
      tally.count_rot90  = CountW'(hits[ROT_90]);
      tally.count_rot180 = CountW'(hits[ROT_180]);
      tally.count_rot270 = CountW'(hits[ROT_270]);
      return tally;
   endfunction

   function automatic void track_item(action_type act, logic [IdxW-1:0] row,
                                      logic [IdxW-1:0] col, logic [CellW-1:0] cell_val);
      case (act)
         ACT_GRID: begin
            grid_cells[row][col]  = cell_val;
            grid_loaded[row][col] = 1'b1;
         end
         ACT_PATTERN: begin
            pattern_cells[row][col]  = cell_val;
            pattern_loaded[row][col] = 1'b1;
         end
         ACT_COMPUTE: expected_counts = {expected_counts, predict_match_counts()};
         default: ;
      endcase
   endfunction

   task automatic send_item(action_type act, logic [IdxW-1:0] row, logic [IdxW-1:0] col,
                            logic [CellW-1:0] cell_val);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= ReqW'({cell_val, col, row});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track_item(act, row, col, cell_val);
   endtask

   task automatic release_req();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic write_csr(csr_index_type idx, logic [SizeW-1:0] value);
      release_req();
      while (expected_counts.size() != 0) @(posedge clock);
      // let a trailing load item retire
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_GRID_SIZE) grid_side = value;
      else pattern_side = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Load every cell a compute item will read under the current sizes
   task automatic fill_unloaded();
      int g, p, r, c;
      g = side_used(grid_side, MaxGrid);
      p = side_used(pattern_side, MaxPattern);
      if (g == 0 || p == 0 || p > g) return;
      for (r = 0; r < g; r++)
         for (c = 0; c < g; c++)
            if (!grid_loaded[r][c]) send_item(ACT_GRID, IdxW'(r), IdxW'(c), pick_cell());
      for (r = 0; r < p; r++)
         for (c = 0; c < p; c++)
            if (!pattern_loaded[r][c]) send_item(ACT_PATTERN, IdxW'(r), IdxW'(c), pick_cell());
   endtask

   // Copy the turned pattern into the grid at (r0, c0)
   task automatic plant_turned(rot_type turn, int r0, int c0, int p);
      int i, j, sr, sc;
      for (i = 0; i < p; i++) begin
         for (j = 0; j < p; j++) begin
            turned_src(turn, i, j, p, sr, sc);
            send_item(ACT_GRID, IdxW'(r0 + i), IdxW'(c0 + j), pattern_cells[sr][sc]);
         end
      end
   endtask

   task automatic test_directed();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      // sizes still at their reset value of 1
      send_item(ACT_GRID, 5'd0, 5'd0, 8'h00);
      send_item(ACT_PATTERN, 5'd0, 5'd0, 8'h00);
      send_item(ACT_COMPUTE, 5'd0, 5'd0, 8'h00);
      send_item(ACT_GRID, 5'd31, 5'd31, 8'hFF);
      send_item(ACT_PATTERN, 5'd31, 5'd31, 8'hFF);
      send_item(ACT_NONE, 5'd31, 5'd31, 8'hFF);
      send_item(ACT_GRID, 5'd0, 5'd0, 8'hFF);
      send_item(ACT_COMPUTE, 5'd31, 5'd31, 8'hFF);
      send_item(ACT_PATTERN, 5'd0, 5'd0, 8'hFF);
      send_item(ACT_COMPUTE, 5'd0, 5'd0, 8'h00);
      // zero sizes
      write_csr(CSR_GRID_SIZE, 6'd0);
      send_item(ACT_COMPUTE, 5'd0, 5'd0, 8'h00);
      write_csr(CSR_GRID_SIZE, 6'd1);
      write_csr(CSR_PATTERN_SIZE, 6'd0);
      send_item(ACT_COMPUTE, 5'd0, 5'd0, 8'h00);
      // pattern larger than grid
      write_csr(CSR_PATTERN_SIZE, 6'd2);
      send_item(ACT_COMPUTE, 5'd0, 5'd0, 8'h00);
      // distinct 2x2 pattern, grid holds its quarter turn
      write_csr(CSR_GRID_SIZE, 6'd2);
      send_item(ACT_PATTERN, 5'd0, 5'd0, 8'h01);
      send_item(ACT_PATTERN, 5'd0, 5'd1, 8'h02);
      send_item(ACT_PATTERN, 5'd1, 5'd0, 8'h03);
      send_item(ACT_PATTERN, 5'd1, 5'd1, 8'h04);
      plant_turned(ROT_90, 0, 0, 2);
      send_item(ACT_COMPUTE, 5'd0, 5'd0, 8'h00);
   endtask

   task automatic test_full_size();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b1;
      // both sizes above the store side: saturate to 32, one placement
      write_csr(CSR_GRID_SIZE, 6'd63);
      write_csr(CSR_PATTERN_SIZE, 6'd33);
      // pattern corners differ from the grid corner: every turn stops at its first cell
      send_item(ACT_GRID, 5'd0, 5'd0, 8'h5A);
      send_item(ACT_PATTERN, 5'd0, 5'd0, 8'hA5);
      send_item(ACT_PATTERN, 5'd0, 5'd31, 8'hA6);
      send_item(ACT_PATTERN, 5'd31, 5'd0, 8'hA7);
      send_item(ACT_PATTERN, 5'd31, 5'd31, 8'hA8);
      send_item(ACT_COMPUTE, 5'd0, 5'd0, 8'h00);
      write_csr(CSR_PATTERN_SIZE, 6'd32);
      send_item(ACT_COMPUTE, 5'd0, 5'd0, 8'h00);
      write_csr(CSR_GRID_SIZE, 6'd32);
      write_csr(CSR_PATTERN_SIZE, 6'd63);
      send_item(ACT_COMPUTE, 5'd0, 5'd0, 8'h00);
   endtask

   task automatic test_result_stall();
      int k;
      write_csr(CSR_GRID_SIZE, 6'd2);
      write_csr(CSR_PATTERN_SIZE, 6'd1);
      fill_unloaded();
      req_gaps_on = 1'b0;
      rsp_hold_req = 400;
      for (k = 0; k < 12; k++) begin
         send_item(ACT_COMPUTE, 5'd0, 5'd0, 8'h00);
         send_item(ACT_GRID, IdxW'($urandom_range(0, 1)), IdxW'($urandom_range(0, 1)),
                   CellW'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_random_traffic();
      int sent, roll, n, k, g, p, eg, ep, span;
      bit usable;
      sent = 0;
      while (sent < RandomItems) begin
         roll = $urandom_range(0, 9);
         if (roll == 0) begin
            if ($urandom_range(0, 1) == 0) begin
               g = $urandom_range(0, 63);
               p = 0;
            end else begin
               g = 0;
               p = $urandom_range(0, 63);
            end
         end else if (roll == 1) begin
            g = $urandom_range(1, 6);
            p = $urandom_range(g + 1, 63);
         end else begin
            g = $urandom_range(1, 8);
            p = $urandom_range(1, (g < 4) ? g : 4);
         end
         write_csr(CSR_GRID_SIZE, SizeW'(g));
         write_csr(CSR_PATTERN_SIZE, SizeW'(p));
         eg = side_used(grid_side, MaxGrid);
         ep = side_used(pattern_side, MaxPattern);
         usable = (eg != 0 && ep != 0 && ep <= eg);
         span = eg - ep;
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         cell_syms[0] = CellW'($urandom_range(0, 255));
         cell_syms[1] = CellW'($urandom_range(0, 255));
         fill_unloaded();
         n = $urandom_range(30, 70);
         for (k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 40 && usable) begin
               send_item(ACT_GRID, IdxW'($urandom_range(0, eg - 1)),
                         IdxW'($urandom_range(0, eg - 1)), pick_cell());
               sent++;
            end else if (roll < 55 && usable) begin
               send_item(ACT_PATTERN, IdxW'($urandom_range(0, ep - 1)),
                         IdxW'($urandom_range(0, ep - 1)), pick_cell());
               sent++;
            end else if (roll < 63 && usable) begin
               plant_turned(rot_type'($urandom_range(0, 3)), $urandom_range(0, span),
                            $urandom_range(0, span), ep);
               sent += ep * ep;
            end else if (roll < 75) begin
               send_item(action_type'($urandom_range(0, 1)), IdxW'($urandom_range(0, 31)),
                         IdxW'($urandom_range(0, 31)), CellW'($urandom_range(0, 255)));
               sent++;
            end else if (roll < 80) begin
               // ignored by the block, not counted
               send_item(ACT_NONE, IdxW'($urandom_range(0, 31)), IdxW'($urandom_range(0, 31)),
                         CellW'($urandom_range(0, 255)));
            end else begin
               send_item(ACT_COMPUTE, IdxW'($urandom_range(0, 31)),
                         IdxW'($urandom_range(0, 31)), CellW'($urandom_range(0, 255)));
               sent++;
            end
         end
         send_item(ACT_COMPUTE, 5'd0, 5'd0, 8'h00);
         sent++;
      end
   endtask

   // Result side: random gaps plus an optional long hold-off
   initial begin
      int hold_left, gap_left;
      hold_left = 0;
      gap_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req > 0) begin
            hold_left = rsp_hold_req;
            rsp_hold_req = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (gap_left > 0) begin
            rsp_tready <= 1'b0;
            gap_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_gaps_on && $urandom_range(0, 3) == 0) gap_left = pick_gap();
         end
      end
   end

   function automatic void compare_count(string field, logic [CountW-1:0] want,
                                         logic [CountW-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      count_set_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_counts.size() == 0) begin
            $error("result item with no compute pending: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = expected_counts.pop_front();
            compare_count("count_rot0", want.count_rot0, rsp_tdata[0 +: CountW]);
            compare_count("count_rot90", want.count_rot90, rsp_tdata[CountW +: CountW]);
            compare_count("count_rot180", want.count_rot180, rsp_tdata[2*CountW +: CountW]);
            compare_count("count_rot270", want.count_rot270, rsp_tdata[3*CountW +: CountW]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = ACT_NONE;
      csr_valid    = 1'b0;
      csr_index    = CSR_GRID_SIZE;
      csr_data     = '0;
      fail_count   = 0;
      quiet_cycles = 0;
      rsp_hold_req = 0;
      req_gaps_on  = 1'b0;
      rsp_gaps_on  = 1'b0;
      grid_side    = 6'd1;
      pattern_side = 6'd1;
      cell_syms[0] = 8'h41;
      cell_syms[1] = 8'h42;
      grid_loaded    = '{default: '{default: 1'b0}};
      pattern_loaded = '{default: '{default: 1'b0}};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_full_size();
      test_result_stall();
      test_random_traffic();

      release_req();
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
